@@ hdl/rlre_pkg.sv @@
`default_nettype none
package rlre_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_ROW_GROUP = 256;
   localparam int MAX_RUN       = 128;

   localparam int COL_W  = $clog2(MAX_WIDTH);   // store index
   localparam int LW_W   = 13;                  // line_width register
   localparam int PH_W   = 16;                  // page_height register
   localparam int MODE_W = 2;
   localparam int CSR_W  = 16;
   localparam int IDX_W  = 2;
   localparam int RC_W   = 9;
   localparam int RUN_W  = 8;

   localparam logic [IDX_W-1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_PAGE_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_PIXEL_MODE  = 2'd2;

   // one queued command beat
   typedef struct packed {
      logic       is_pull;
      logic [7:0] chan_0;
      logic [7:0] chan_1;
      logic [7:0] chan_2;
      logic [7:0] chan_3;
   } cmd_type;

endpackage
`default_nettype wire

@@ hdl/rlre_front.sv @@
`default_nettype none
module rlre_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_command,
   input  wire logic [7:0]      req_chan_0,
   input  wire logic [7:0]      req_chan_1,
   input  wire logic [7:0]      req_chan_2,
   input  wire logic [7:0]      req_chan_3,
   output logic                 q_valid,
   output rlre_pkg::cmd_type    q_item,
   input  wire logic            q_pop
);
   import rlre_pkg::*;

   cmd_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    beat;

   always_comb begin
      beat.is_pull = req_command;
      beat.chan_0  = req_chan_0;
      beat.chan_1  = req_chan_1;
      beat.chan_2  = req_chan_2;
      beat.chan_3  = req_chan_3;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= beat;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/rlre_back.sv @@
`default_nettype none
module rlre_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [rlre_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [rlre_pkg::CSR_W-1:0]  csr_data,
   input  wire logic                        q_valid,
   input  wire rlre_pkg::cmd_type           q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_push_accepted,
   output logic                             rsp_byte_valid,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_page_done
);
   import rlre_pkg::*;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_ROWHDR = 3'd1;
   localparam logic [2:0] PH_RUNHDR = 3'd2;
   localparam logic [2:0] PH_REPPIX = 3'd3;
   localparam logic [2:0] PH_LITPIX = 3'd4;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PUSH      = 4'd1;
   localparam logic [3:0] S_HDR_FIRST = 4'd2;
   localparam logic [3:0] S_LIT_CHK   = 4'd3;
   localparam logic [3:0] S_LIT_CMP   = 4'd4;
   localparam logic [3:0] S_LIT_END   = 4'd5;
   localparam logic [3:0] S_REP_CHK   = 4'd6;
   localparam logic [3:0] S_REP_CMP   = 4'd7;
   localparam logic [3:0] S_PIX       = 4'd8;

   localparam int ADDR_W = COL_W + 1;

   // two row banks: bank_ff selects the reference, the other takes pushes
   logic [31:0] mem [2**ADDR_W];
   logic [31:0] rd_q_ff;
   logic [COL_W-1:0] rd_col;
   logic        wr_en;

   logic [LW_W-1:0]   lw_ff;
   logic [PH_W-1:0]   ph_ff;
   logic [MODE_W-1:0] mode_ff;

   logic [3:0]       st_ff, st_in;
   cmd_type          item_ff, item_in;
   logic [RC_W-1:0]  rc_ff, rc_in;
   logic [PH_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             match_ff, match_in;
   logic             refp_ff, refp_in;
   logic [2:0]       phase_ff, phase_in;
   logic [LW_W-1:0]  ec_ff, ec_in;
   logic [RUN_W-1:0] rr_ff, rr_in;
   logic [1:0]       bs_ff, bs_in;
   logic             glast_ff, glast_in;
   logic             pend_ff, pend_in;
   logic             plast_ff, plast_in;
   logic             bank_ff, bank_in;
   logic [RUN_W-1:0] d_ff, d_in;
   logic [31:0]      base_ff, base_in, prev_ff, prev_in;

   logic       rv_ff, rv_in, pa_ff, pa_in, bv_ff, bv_in, pd_ff, pd_in;
   logic [7:0] ob_ff, ob_in;

   logic [LW_W-1:0]   w;
   logic              rsp_free;
   logic [31:0]       pix;
   logic [LW_W:0]     xd;
   logic              scan_ok;
   logic              last_row;
   logic              row_end;
   logic [LW_W-1:0]   ec_new;
   logic [RUN_W-1:0]  rr_new;
   logic              run_end;
   logic [RC_W-1:0]   rc_inc;
   logic [7:0]        sel_byte;
   logic              match_new;

   always_comb begin
      if (lw_ff == '0) begin
         w = LW_W'(1);
      end else if (lw_ff > LW_W'(MAX_WIDTH)) begin
         w = LW_W'(MAX_WIDTH);
      end else begin
         w = lw_ff;
      end
   end

   always_comb begin
      pix = {24'd0, item_ff.chan_0};
      if (mode_ff != 2'd0) begin
         pix[15:8] = item_ff.chan_1;
      end
      if (mode_ff[1]) begin
         pix[31:16] = {item_ff.chan_3, item_ff.chan_2};
      end
   end

   always_comb begin
      case (bs_ff)
         2'd0:    sel_byte = rd_q_ff[7:0];
         2'd1:    sel_byte = rd_q_ff[15:8];
         2'd2:    sel_byte = rd_q_ff[23:16];
         default: sel_byte = rd_q_ff[31:24];
      endcase
   end

   assign rsp_free = !rv_ff || !rsp_stall;
   assign xd       = {1'b0, ec_ff} + {{(LW_W+1-RUN_W){1'b0}}, d_ff};
   assign scan_ok  = (d_ff < RUN_W'(MAX_RUN)) && (xd < {1'b0, w});
   assign last_row = ({1'b0, row_ff} + 17'd1) >= {1'b0, ph_ff};
   assign row_end  = ({1'b0, col_ff} + 13'd1) >= w;
   assign rc_inc   = rc_ff + 9'd1;
   assign match_new = match_ff && !(refp_ff && (rd_q_ff != pix));

   always_comb begin
      st_in    = st_ff;
      item_in  = item_ff;
      rc_in    = rc_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      match_in = match_ff;
      refp_in  = refp_ff;
      phase_in = phase_ff;
      ec_in    = ec_ff;
      rr_in    = rr_ff;
      bs_in    = bs_ff;
      glast_in = glast_ff;
      pend_in  = pend_ff;
      plast_in = plast_ff;
      bank_in  = bank_ff;
      d_in     = d_ff;
      base_in  = base_ff;
      prev_in  = prev_ff;
      rv_in    = rv_ff && rsp_stall;
      pa_in    = pa_ff;
      bv_in    = bv_ff;
      ob_in    = ob_ff;
      pd_in    = pd_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      rd_col   = ec_ff[COL_W-1:0];
      ec_new   = ec_ff;
      rr_new   = rr_ff;
      run_end  = 1'b0;

      unique case (st_ff) inside
         S_IDLE: begin
            if (phase_ff == PH_IDLE) begin
               rd_col = col_ff;
            end
            if (q_valid && rsp_free) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (!q_item.is_pull) begin
                  if (phase_ff != PH_IDLE) begin
                     rv_in = 1'b1; pa_in = 1'b0; bv_in = 1'b0;
                     ob_in = 8'd0; pd_in = 1'b0;
                  end else begin
                     st_in = S_PUSH;
                  end
               end else begin
                  unique case (phase_ff) inside
                     PH_ROWHDR: begin
                        rv_in = 1'b1; pa_in = 1'b0; bv_in = 1'b1;
                        ob_in = 8'(rc_ff - 9'd1); pd_in = 1'b0;
                        phase_in = PH_RUNHDR;
                     end
                     PH_RUNHDR: st_in = S_HDR_FIRST;
                     PH_REPPIX, PH_LITPIX: st_in = S_PIX;
                     default: begin
                        rv_in = 1'b1; pa_in = 1'b0; bv_in = 1'b0;
                        ob_in = 8'd0; pd_in = 1'b0;
                     end
                  endcase
               end
            end
         end

         S_PUSH: begin
            wr_en = 1'b1;
            rv_in = 1'b1; pa_in = 1'b1; bv_in = 1'b0; ob_in = 8'd0; pd_in = 1'b0;
            match_in = match_new;
            st_in = S_IDLE;
            if (!row_end) begin
               col_in = col_ff + 12'd1;
            end else begin
               row_in   = last_row ? '0 : row_ff + 16'd1;
               col_in   = '0;
               match_in = 1'b1;
               if (!refp_ff) begin
                  bank_in = ~bank_ff;
                  rc_in   = 9'd1;
                  refp_in = 1'b1;
                  if (last_row) begin
                     glast_in = 1'b1; phase_in = PH_ROWHDR;
                     ec_in = '0; bs_in = '0; rr_in = '0;
                  end
               end else if (match_new && rc_ff < RC_W'(MAX_ROW_GROUP)) begin
                  rc_in = rc_inc;
                  if (last_row || rc_inc >= RC_W'(MAX_ROW_GROUP)) begin
                     glast_in = last_row; phase_in = PH_ROWHDR;
                     ec_in = '0; bs_in = '0; rr_in = '0;
                  end
               end else begin
                  pend_in  = 1'b1;
                  plast_in = last_row;
                  glast_in = 1'b0; phase_in = PH_ROWHDR;
                  ec_in = '0; bs_in = '0; rr_in = '0;
               end
            end
         end

         S_HDR_FIRST: begin
            base_in = rd_q_ff;
            prev_in = rd_q_ff;
            d_in    = RUN_W'(1);
            st_in   = S_LIT_CHK;
         end

         S_LIT_CHK: begin
            rd_col = xd[COL_W-1:0];
            st_in  = scan_ok ? S_LIT_CMP : S_LIT_END;
         end

         S_LIT_CMP: begin
            if (rd_q_ff == prev_ff) begin
               st_in = S_LIT_END;
            end else begin
               prev_in = rd_q_ff;
               d_in    = d_ff + 8'd1;
               st_in   = S_LIT_CHK;
            end
         end

         S_LIT_END: begin
            if (d_ff == 8'd1) begin
               st_in = S_REP_CHK;
            end else begin
               rv_in = 1'b1; pa_in = 1'b0; bv_in = 1'b1; pd_in = 1'b0;
               ob_in = 8'(9'd257 - {1'b0, d_ff});
               rr_in = d_ff; bs_in = '0; phase_in = PH_LITPIX;
               st_in = S_IDLE;
            end
         end

         S_REP_CHK, S_REP_CMP: begin
            rd_col = xd[COL_W-1:0];
            if (st_ff == S_REP_CHK && scan_ok) begin
               st_in = S_REP_CMP;
            end else if (st_ff == S_REP_CMP && rd_q_ff == base_ff) begin
               d_in  = d_ff + 8'd1;
               st_in = S_REP_CHK;
            end else begin
               // repeat run closed: n = d
               rv_in = 1'b1; pa_in = 1'b0; bv_in = 1'b1; pd_in = 1'b0;
               ob_in = d_ff - 8'd1;
               rr_in = d_ff; bs_in = '0; phase_in = PH_REPPIX;
               st_in = S_IDLE;
            end
         end

         S_PIX: begin
            rv_in = 1'b1; pa_in = 1'b0; bv_in = 1'b1; pd_in = 1'b0;
            ob_in = sel_byte;
            st_in = S_IDLE;
            if (mode_ff[1] && bs_ff < 2'd2) begin
               bs_in = bs_ff + 2'd1;
            end else begin
               bs_in = '0;
               if (phase_ff == PH_REPPIX) begin
                  ec_new  = ec_ff + {{(LW_W-RUN_W){1'b0}}, rr_ff};
                  rr_new  = '0;
                  run_end = 1'b1;
               end else begin
                  ec_new  = ec_ff + 13'd1;
                  rr_new  = (rr_ff != '0) ? rr_ff - 8'd1 : rr_ff;
                  run_end = (rr_new == '0);
               end
               ec_in = ec_new;
               rr_in = rr_new;
               if (run_end) begin
                  if (ec_new >= w) begin
                     pd_in    = glast_ff;
                     phase_in = PH_IDLE;
                     refp_in  = 1'b0;
                     if (pend_ff) begin
                        bank_in = ~bank_ff;
                        pend_in = 1'b0;
                        rc_in   = 9'd1;
                        refp_in = 1'b1;
                        if (plast_ff) begin
                           glast_in = 1'b1; phase_in = PH_ROWHDR;
                           ec_in = '0; bs_in = '0; rr_in = '0;
                        end
                     end
                  end else begin
                     phase_in = PH_RUNHDR;
                  end
               end
            end
         end

         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{~bank_ff, col_ff}] <= pix;
      end
      rd_q_ff <= mem[{bank_ff, rd_col}];
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      d_ff    <= d_in;
      base_ff <= base_in;
      prev_ff <= prev_in;
      pa_ff   <= pa_in;
      bv_ff   <= bv_in;
      ob_ff   <= ob_in;
      pd_ff   <= pd_in;
      if (reset) begin
         lw_ff    <= LW_W'(1);
         ph_ff    <= PH_W'(1);
         mode_ff  <= '0;
         st_ff    <= S_IDLE;
         rc_ff    <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         match_ff <= 1'b1;
         refp_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
         ec_ff    <= '0;
         rr_ff    <= '0;
         bs_ff    <= '0;
         glast_ff <= 1'b0;
         pend_ff  <= 1'b0;
         plast_ff <= 1'b0;
         bank_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LINE_WIDTH:  lw_ff   <= csr_data[LW_W-1:0];
               CSR_PAGE_HEIGHT: ph_ff   <= csr_data[PH_W-1:0];
               CSR_PIXEL_MODE:  mode_ff <= csr_data[MODE_W-1:0];
               default: ;
            endcase
         end
         st_ff    <= st_in;
         rc_ff    <= rc_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         match_ff <= match_in;
         refp_ff  <= refp_in;
         phase_ff <= phase_in;
         ec_ff    <= ec_in;
         rr_ff    <= rr_in;
         bs_ff    <= bs_in;
         glast_ff <= glast_in;
         pend_ff  <= pend_in;
         plast_ff <= plast_in;
         bank_ff  <= bank_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_push_accepted = pa_ff;
   assign rsp_byte_valid    = bv_ff;
   assign rsp_out_byte      = ob_ff;
   assign rsp_page_done     = pd_ff;

endmodule
`default_nettype wire

@@ hdl/raster_line_repeat_run_encoder_unit.sv @@
`default_nettype none
// Raster line repeat-run encoder (PackBits style row compression, header signs swapped).
// req_* beats carry a command: push one pixel (chan_0..3, bytes by pixel_mode)
// or pull one byte of the encoded stream. Every request beat gives exactly one
// rsp_* beat, in order: push_accepted, byte_valid, out_byte, page_done.
// csr_*: write-only registers (0 line_width, 1 page_height, 2 pixel_mode);
// the user must write them only while the unit is quiet; no check enforces it.
// A push reads the reference pixel, then compares and stores. A run header
// scans the reference row through the single read port of the line store,
// one read and one compare per pixel looked at; the literal length d and
// the repeat length n are each at most 128.
// A two-beat queue in front takes requests while the engine works; a result
// register at the back holds a beat while rsp_stall is high, and the engine
// only starts the next request once that register is free or being emptied.
// Reset (synchronous) empties the queue, drops any result, returns registers
// to line_width 1, page_height 1, gray mode; line store contents stay
// undefined until written, no clearing pass is needed.
module raster_line_repeat_run_encoder_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_command,
   input  wire logic [7:0]                  req_chan_0,
   input  wire logic [7:0]                  req_chan_1,
   input  wire logic [7:0]                  req_chan_2,
   input  wire logic [7:0]                  req_chan_3,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_push_accepted,
   output logic                             rsp_byte_valid,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_page_done,
   input  wire logic                        csr_wr_en,
   input  wire logic [rlre_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [rlre_pkg::CSR_W-1:0]  csr_data
);
   import rlre_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_item;

   // front: request queue and command decode
   rlre_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_chan_0  (req_chan_0),
      .req_chan_1  (req_chan_1),
      .req_chan_2  (req_chan_2),
      .req_chan_3  (req_chan_3),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // back: line store, row grouping, run encoder and result register
   rlre_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_push_accepted (rsp_push_accepted),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_page_done     (rsp_page_done)
   );

endmodule
`default_nettype wire

@@ tb/rlre_encode_monitor.sv @@
// Passive monitor: predicts every response beat from the accepted request
// beats and register writes, then compares in order.
module rlre_encode_monitor
   import rlre_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_command,
   input  wire logic [7:0]        req_chan_0,
   input  wire logic [7:0]        req_chan_1,
   input  wire logic [7:0]        req_chan_2,
   input  wire logic [7:0]        req_chan_3,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_push_accepted,
   input  wire logic              rsp_byte_valid,
   input  wire logic [7:0]        rsp_out_byte,
   input  wire logic              rsp_page_done,
   input  wire logic              csr_wr_en,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count,
   output logic                   draining
);

   typedef enum logic [2:0] {
      EM_IDLE, EM_ROWHDR, EM_RUNHDR, EM_REPPIX, EM_LITPIX
   } emit_type;

   typedef struct packed {
      logic       pa;
      logic       bv;
      logic [7:0] ob;
      logic       pd;
   } beat_type;

   beat_type    want_q[$];

   int unsigned lw, ph, pm;
   logic [31:0] ref_row [MAX_WIDTH];
   logic [31:0] in_row  [MAX_WIDTH];
   int unsigned rep_cnt, row_idx, col;
   bit          match, ref_ok;
   emit_type    phase;
   int unsigned emit_col, run_left, bsel;
   bit          grp_last, pend, pend_last;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      draining      = 1'b0;
   end

   function automatic int unsigned eff_w();
      if (lw == 0) return 1;
      if (lw > MAX_WIDTH) return MAX_WIDTH;
      return lw;
   endfunction

   function automatic void start_drain(input bit last);
      grp_last = last;
      phase    = EM_ROWHDR;
      emit_col = 0;
      bsel     = 0;
      run_left = 0;
   endfunction

   function automatic void finish_drain();
      phase  = EM_IDLE;
      ref_ok = 1'b0;
      if (pend) begin
         ref_row = in_row;
         pend    = 1'b0;
         rep_cnt = 1;
         ref_ok  = 1'b1;
         if (pend_last || rep_cnt >= MAX_ROW_GROUP) start_drain(pend_last);
      end
   endfunction

   function automatic bit end_run();
      bit done;
      done = 1'b0;
      if (emit_col >= eff_w()) begin
         done = grp_last;
         finish_drain();
      end else begin
         phase = EM_RUNHDR;
      end
      return done;
   endfunction

   function automatic void row_done();
      bit last;
      last    = (row_idx + 1 >= ph);
      row_idx = last ? 0 : ((row_idx + 1) & 16'hffff);
      col     = 0;
      if (!ref_ok) begin
         ref_row = in_row;
         rep_cnt = 1;
         ref_ok  = 1'b1;
         if (last || rep_cnt >= MAX_ROW_GROUP) start_drain(last);
      end else if (match && rep_cnt < MAX_ROW_GROUP) begin
         rep_cnt++;
         if (last || rep_cnt >= MAX_ROW_GROUP) start_drain(last);
      end else begin
         pend      = 1'b1;
         pend_last = last;
         start_drain(1'b0);
      end
      match = 1'b1;
   endfunction

   function automatic beat_type encode_step(input logic is_pull, input logic [31:0] raw);
      beat_type    r;
      int unsigned w, x, d, n, c;
      logic [31:0] p;
      r = '0;
      w = eff_w();
      if (!is_pull) begin
         if (phase != EM_IDLE) return r;    // refused while a group drains
         p = {24'h0, raw[7:0]};
         if (pm >= 1) p[15:8] = raw[15:8];
         if (pm >= 2) p[31:16] = raw[31:16];
         c = col % MAX_WIDTH;
         in_row[c] = p;
         if (ref_ok && ref_row[c] != p) match = 1'b0;
         r.pa = 1'b1;
         if (col + 1 >= w) row_done();
         else col = (col + 1) & 12'hfff;
         return r;
      end
      case (phase) inside
         EM_ROWHDR: begin
            r.ob  = 8'(rep_cnt - 1);
            r.bv  = 1'b1;
            phase = EM_RUNHDR;
         end
         EM_RUNHDR: begin
            x = emit_col;
            d = 1;
            while (d < MAX_RUN && x + d < w) begin
               if (ref_row[(x + d - 1) % MAX_WIDTH] == ref_row[(x + d) % MAX_WIDTH]) break;
               d++;
            end
            if (d == 1) begin
               n = 1;
               while (n < MAX_RUN && x + n < w &&
                      ref_row[(x + n) % MAX_WIDTH] == ref_row[x % MAX_WIDTH]) n++;
               r.ob     = 8'(n - 1);
               run_left = n;
               phase    = EM_REPPIX;
            end else begin
               r.ob     = 8'(257 - d);
               run_left = d;
               phase    = EM_LITPIX;
            end
            bsel = 0;
            r.bv = 1'b1;
         end
         EM_REPPIX, EM_LITPIX: begin
            r.ob = 8'(ref_row[emit_col % MAX_WIDTH] >> (8 * (bsel & 3)));
            r.bv = 1'b1;
            if (bsel + 1 >= ((pm >= 2) ? 3 : 1)) begin
               bsel = 0;
               if (phase == EM_REPPIX) begin
                  emit_col += run_left;
                  run_left = 0;
                  r.pd = end_run();
               end else begin
                  emit_col++;
                  if (run_left > 0) run_left--;
                  if (run_left == 0) r.pd = end_run();
               end
            end else begin
               bsel++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      beat_type want, got;
      if (reset) begin
         lw = 1; ph = 1; pm = 0;
         rep_cnt = 0; row_idx = 0; col = 0;
         match = 1'b1; ref_ok = 1'b0;
         phase = EM_IDLE; emit_col = 0; run_left = 0; bsel = 0;
         grp_last = 1'b0; pend = 1'b0; pend_last = 1'b0;
         want_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LINE_WIDTH:  lw = csr_data[12:0];
               CSR_PAGE_HEIGHT: ph = csr_data[15:0];
               CSR_PIXEL_MODE:  pm = csr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_push_accepted, rsp_byte_valid, rsp_out_byte, rsp_page_done};
            if (want_q.size() == 0) begin
               $display("%0t: response beat with nothing expected, got %0h", $time, got);
               fail_count++;
            end else begin
               want = want_q.pop_front();
               if (got.pa != want.pa) report("push_accepted", want.pa, got.pa);
               if (got.bv != want.bv) report("byte_valid", want.bv, got.bv);
               if (got.ob != want.ob) report("out_byte", want.ob, got.ob);
               if (got.pd != want.pd) report("page_done", want.pd, got.pd);
            end
         end
         if (req_valid && !req_stall)
            want_q.push_back(encode_step(req_command,
                             {req_chan_3, req_chan_2, req_chan_1, req_chan_0}));
      end
      pending_count = want_q.size();
      draining      = (phase != EM_IDLE);
   end

endmodule

@@ tb/tb_raster_line_repeat_run_encoder_unit.sv @@
// Top: drives pixel rows and pull beats, stalls the response side at random,
// and gives the verdict from the monitor's failure count.
module tb_raster_line_repeat_run_encoder_unit;
   import rlre_pkg::*;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_PULL = 1'b1;
   localparam int   WATCHDOG = 5000;   // longest run header scan plus long stalls, many times over

   // row content styles
   typedef enum int {K_ZERO, K_ONES, K_CONST, K_PAL, K_RAND, K_INC, K_SAME, K_ANY} row_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_command = 1'b0;
   logic [7:0]       req_chan_0 = '0, req_chan_1 = '0, req_chan_2 = '0, req_chan_3 = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_push_accepted, rsp_byte_valid, rsp_page_done;
   logic [7:0]       rsp_out_byte;
   logic             csr_wr_en = 1'b0;
   logic [IDX_W-1:0] csr_index = CSR_LINE_WIDTH;
   logic [CSR_W-1:0] csr_data = '0;

   int               fail_count, pending_count;
   logic             draining;

   logic [31:0]      row_px [MAX_WIDTH];
   int               beats = 0, pulls = 0, phases = 0;
   bit               no_gaps = 1'b0;     // phase-wide: no idling on either side
   int               stall_left = 0;
   int               idle_cycles = 0;

   always #5 clock = ~clock;

   raster_line_repeat_run_encoder_unit uut (.*);

   rlre_encode_monitor mon (.*);

   // Response side backpressure: mostly short stalls, now and then a long one.
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset || no_gaps) begin
         rsp_stall  = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (r < 65) begin
         rsp_stall = 1'b0;
      end else if (r < 94) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall  = 1'b1;
      end else begin
         stall_left = $urandom_range(10, 40);
         rsp_stall  = 1'b1;
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("tb_raster_line_repeat_run_encoder_unit: errors");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // One request beat; returns just after its acceptance edge has settled.
   task automatic put_beat(input logic cmd, input logic [31:0] px);
      int g;
      g = gap_len();
      repeat (g) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid   = 1'b1;
      req_command = cmd;
      {req_chan_3, req_chan_2, req_chan_1, req_chan_0} = px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      #1;
      beats++;
      if (cmd == CMD_PULL) pulls++;
   endtask

   // Wait until every predicted beat has come back.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data  = CSR_W'(val);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Pull bytes as long as a group is draining; sprinkle refused pushes.
   task automatic drain_groups();
      while (draining) begin
         if ($urandom_range(0, 99) < 10) put_beat(CMD_PUSH, $urandom);
         put_beat(CMD_PULL, $urandom);
      end
      if ($urandom_range(0, 99) < 15) put_beat(CMD_PULL, $urandom);   // pull while idle
   endtask

   task automatic make_row(input int w, input row_kind_type kind);
      logic [31:0]  pal [3];
      logic [31:0]  v;
      int           c, len;
      row_kind_type k;
      k = kind;
      if (k == K_ANY) begin
         case ($urandom_range(0, 9)) inside
            [0:2]:   k = K_SAME;
            3:       k = K_CONST;
            [4:7]:   k = K_PAL;
            default: k = K_RAND;
         endcase
      end
      foreach (pal[i]) pal[i] = $urandom;
      v = $urandom;
      c = 0;
      while (c < w) begin
         case (k)
            K_ZERO:  row_px[c] = 32'h0;
            K_ONES:  row_px[c] = 32'hffff_ffff;
            K_CONST: row_px[c] = v;
            K_RAND:  row_px[c] = $urandom;
            K_INC:   row_px[c] = 32'(c) ^ v;
            K_PAL: begin
               // short runs drawn from a tiny palette make both run types
               v   = pal[$urandom_range(0, 2)];
               len = $urandom_range(1, 4);
               while (len > 0 && c < w) begin
                  row_px[c] = v;
                  c++;
                  len--;
               end
               c--;
            end
            default: ;   // K_SAME keeps the previous row
         endcase
         c++;
      end
   endtask

   task automatic push_row(input int w);
      for (int c = 0; c < w; c++) begin
         if ($urandom_range(0, 99) < 4) put_beat(CMD_PULL, $urandom);   // idle pull mid-row
         put_beat(CMD_PUSH, row_px[c]);
      end
      drain_groups();
   endtask

   // Registers change only with the unit quiet and at a page boundary.
   task automatic run_phase(input int lw, input int ph, input int mode, input int rows,
                            input row_kind_type first_kind, input row_kind_type rest_kind);
      int w;
      settle();
      repeat (4) @(negedge clock);
      write_reg(CSR_LINE_WIDTH, lw);
      write_reg(CSR_PAGE_HEIGHT, ph);
      write_reg(CSR_PIXEL_MODE, mode);
      w = (lw == 0) ? 1 : (lw > MAX_WIDTH) ? MAX_WIDTH : lw;
      no_gaps = ($urandom_range(0, 4) == 0);
      phases++;
      for (int r = 0; r < rows; r++) begin
         make_row(w, (r == 0) ? first_kind : rest_kind);
         push_row(w);
      end
   endtask

   initial begin
      int start, lw, ph, mode;
      foreach (row_px[i]) row_px[i] = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: zero width/height act as one, extreme pixel values
      run_phase(0, 0, 0, 1, K_ZERO, K_ZERO);
      run_phase(1, 1, 0, 1, K_ONES, K_ONES);
      // identical rows merge into one group; gray+alpha drops alpha
      run_phase(3, 2, 1, 2, K_PAL, K_SAME);
      // differing row on the last row: old group drains, then the new one
      run_phase(5, 2, 2, 2, K_RAND, K_RAND);
      // mode 3 behaves as rgb+alpha
      run_phase(4, 1, 3, 1, K_ONES, K_ONES);
      run_phase(6, 3, 2, 3, K_PAL, K_ANY);

      // random pages, mostly narrow rows
      start = beats;
      while (beats - start < 210) begin
         lw   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         ph   = $urandom_range(0, 4);
         mode = $urandom_range(0, 3);
         run_phase(lw, ph, mode, ((ph == 0) ? 1 : ph) * $urandom_range(1, 3), K_ANY, K_ANY);
      end

      // tall page of one-pixel rows: a full group of identical rows drains on its own
      run_phase(1, 65535, 0, 258, K_PAL, K_SAME);

      settle();
      repeat (20) @(negedge clock);
      $display("covered %0d request beats (%0d pulls) over %0d register settings",
               beats, pulls, phases);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_raster_line_repeat_run_encoder_unit: clean");
      end else begin
         $display("tb_raster_line_repeat_run_encoder_unit: errors");
      end
      $finish;
   end

endmodule
